/* rtl/core/bso_pkg.sv */
// ----------------------------------------------------------------------------
// bso_pkg: shared types and constants for the boundary segment overlap check
// Edge record layout, store geometry and arithmetic widths of the pair test.
// ----------------------------------------------------------------------------
package bso_pkg;

  localparam int MAX_EDGES  = 256;
  localparam int COORD_BITS = 16;
  localparam int ADDR_W     = $clog2(MAX_EDGES);
  localparam int CNT_W      = $clog2(MAX_EDGES + 1);

  localparam int TOL_W      = 32;
  localparam logic [TOL_W-1:0] TOL_RESET = 32'd26844;

  // Coordinate difference, product, sum of two products, compare width
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CMP_W  = (SUM_W > TOL_W ? SUM_W : TOL_W) + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } seg_t;

endpackage

/* rtl/core/bso_pair_test.sv */
// ----------------------------------------------------------------------------
// bso_pair_test: pipelined overlap test of two segments
// Four stages: differences, products, cross and dot sums, compares. One pair
// enters per cycle; the verdict leaves from the compare register.
// ----------------------------------------------------------------------------
module bso_pair_test
  import bso_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             pair_valid,
  input  seg_t             p,
  input  seg_t             q,
  input  logic [TOL_W-1:0] tol,
  output logic             res_valid,
  output logic             res_hit,
  output logic             busy
);

  // Stage 1: coordinate differences
  logic                     v1;
  logic signed [DIFF_W-1:0] abx, aby, cdx, cdy;
  logic signed [DIFF_W-1:0] ox [4];
  logic signed [DIFF_W-1:0] oy [4];
  logic signed [DIFF_W-1:0] ex [4];
  logic signed [DIFF_W-1:0] ey [4];

  // Stage 2: products
  logic                     v2;
  logic signed [PROD_W-1:0] po_a [4];
  logic signed [PROD_W-1:0] po_b [4];
  logic signed [PROD_W-1:0] pc_a [4];
  logic signed [PROD_W-1:0] pc_b [4];
  logic signed [PROD_W-1:0] pd_a [4];
  logic signed [PROD_W-1:0] pd_b [4];
  logic signed [PROD_W-1:0] pl   [4];

  // Stage 3: cross products, dot products, squared lengths
  logic                    v3;
  logic signed [SUM_W-1:0] cr_o [4];
  logic signed [SUM_W-1:0] cr_e [4];
  logic signed [SUM_W-1:0] dt   [4];
  logic signed [SUM_W-1:0] len2 [2];

  // Stage 4 result
  logic v4;
  logic hit4;

  logic signed [CMP_W-1:0] tol_s;
  logic                    orient_hit;
  logic [3:0]              on_open;
  logic [3:0]              pos, neg;

  function automatic logic signed [DIFF_W-1:0] dif(coord_t a, coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  always_ff @(posedge clk) begin
    abx   <= dif(p.bx, p.ax);
    aby   <= dif(p.by, p.ay);
    cdx   <= dif(q.bx, q.ax);
    cdy   <= dif(q.by, q.ay);
    ox[0] <= dif(q.ax, p.bx);
    oy[0] <= dif(q.ay, p.by);
    ox[1] <= dif(q.bx, p.bx);
    oy[1] <= dif(q.by, p.by);
    ox[2] <= dif(p.ax, q.bx);
    oy[2] <= dif(p.ay, q.by);
    ox[3] <= dif(p.bx, q.bx);
    oy[3] <= dif(p.by, q.by);
    ex[0] <= dif(q.ax, p.ax);
    ey[0] <= dif(q.ay, p.ay);
    ex[1] <= dif(q.bx, p.ax);
    ey[1] <= dif(q.by, p.ay);
    ex[2] <= dif(p.ax, q.ax);
    ey[2] <= dif(p.ay, q.ay);
    ex[3] <= dif(p.bx, q.ax);
    ey[3] <= dif(p.by, q.ay);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (k < 2) begin
        po_a[k] <= abx * oy[k];
        po_b[k] <= aby * ox[k];
        pc_a[k] <= ex[k] * aby;
        pc_b[k] <= ey[k] * abx;
        pd_a[k] <= abx * ex[k];
        pd_b[k] <= aby * ey[k];
      end else begin
        po_a[k] <= cdx * oy[k];
        po_b[k] <= cdy * ox[k];
        pc_a[k] <= ex[k] * cdy;
        pc_b[k] <= ey[k] * cdx;
        pd_a[k] <= cdx * ex[k];
        pd_b[k] <= cdy * ey[k];
      end
    end
    pl[0] <= abx * abx;
    pl[1] <= aby * aby;
    pl[2] <= cdx * cdx;
    pl[3] <= cdy * cdy;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      cr_o[k] <= SUM_W'(po_a[k]) - SUM_W'(po_b[k]);
      cr_e[k] <= SUM_W'(pc_a[k]) - SUM_W'(pc_b[k]);
      dt[k]   <= SUM_W'(pd_a[k]) + SUM_W'(pd_b[k]);
    end
    len2[0] <= SUM_W'(pl[0]) + SUM_W'(pl[1]);
    len2[1] <= SUM_W'(pl[2]) + SUM_W'(pl[3]);
  end

  // Strict sign test for proper crossing, tolerance test for touching
  always_comb begin
    tol_s = $signed({{(CMP_W - TOL_W){1'b0}}, tol});
    for (int k = 0; k < 4; k++) begin
      pos[k] = cr_o[k] > 0;
      neg[k] = cr_o[k] < 0;
      on_open[k] = (CMP_W'(cr_e[k]) <= tol_s) && (CMP_W'(cr_e[k]) >= -tol_s) &&
                   (tol_s < CMP_W'(dt[k])) && (dt[k] < len2[k / 2]);
    end
    orient_hit = ((pos[0] & neg[1]) | (neg[0] & pos[1])) &
                 ((pos[2] & neg[3]) | (neg[2] & pos[3]));
  end

  always_ff @(posedge clk) begin
    hit4 <= orient_hit | (|on_open);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= pair_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign res_valid = v4;
  assign res_hit   = hit4;
  assign busy      = v1 | v2 | v3 | v4;

endmodule

/* rtl/core/boundary_segment_overlap_check.sv */
// ----------------------------------------------------------------------------
// boundary_segment_overlap_check: pairwise overlap test of boundary edges
// Store edges one beat at a time; on the last edge test every stored pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one edge per beat: two endpoints
//   in signed fixed point with 14 fraction bits, plus last_edge. Edges go into
//   an on-chip store of MAX_EDGES entries; edges beyond that are dropped and
//   flagged. in_ready stays high after a beat unless it carries last_edge.
//   The last edge starts the pair sweep: one memory read per cycle feeds a
//   four-stage pair test; the sweep is paced by the single read port of the
//   edge store. in_ready is low during the sweep.
//   Output channel (out_valid/out_ready) carries one beat per set: overlap
//   and overflowed. The result sits in an output register, so a new set can
//   load while the receiver stalls; a second finished set waits for the
//   slot before its result is written.
//   Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the 32-bit
//   tolerance; write it only while no set is in flight.
//   Reset clears the edge count, the drop flag and the output register and
//   restores the default tolerance; no clearing pass is needed.
// ----------------------------------------------------------------------------
module boundary_segment_overlap_check
  import bso_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TOL_W-1:0]      cfg_data,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic                  last_edge,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  overlap,
  output logic                  overflowed
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FETCH  = 3'd1;
  localparam logic [2:0] ST_SWEEP  = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]       state;
  logic [TOL_W-1:0] tolerance;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] last_idx;
  logic             dropped;
  logic             hit;
  logic [ADDR_W-1:0] i_idx;
  logic [ADDR_W-1:0] j_idx;
  logic [ADDR_W-1:0] raddr;
  logic             rd_p;
  logic             rd_q;
  logic             accept;
  logic             room;

  // Edge store: one write port for loading, one registered read port for
  // the sweep
  seg_t edge_store [MAX_EDGES];
  seg_t rdata;
  seg_t wr_seg;
  seg_t p_seg;

  logic res_valid;
  logic res_hit;
  logic pipe_busy;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign room      = count < CNT_W'(MAX_EDGES);
  assign count_next = room ? count + CNT_W'(1) : count;

  assign wr_seg = '{ax: start_x, ay: start_y, bx: end_x, by: end_y};

  // Fetch reads the fixed edge, sweep reads its partners
  assign raddr = (state == ST_FETCH) ? i_idx : j_idx;

  always_ff @(posedge clk) begin
    if (accept && room) begin
      edge_store[count[ADDR_W-1:0]] <= wr_seg;
    end
    rdata <= edge_store[raddr];
  end

  // Latch the fixed edge when its read returns
  always_ff @(posedge clk) begin
    if (rd_p) begin
      p_seg <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      last_idx   <= '0;
      dropped    <= 1'b0;
      hit        <= 1'b0;
      i_idx      <= '0;
      j_idx      <= '0;
      rd_p       <= 1'b0;
      rd_q       <= 1'b0;
      out_valid  <= 1'b0;
      overlap    <= 1'b0;
      overflowed <= 1'b0;
    end else begin
      rd_p <= 1'b0;
      rd_q <= 1'b0;

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (res_valid && res_hit) begin
        hit <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            count <= count_next;
            if (!room) begin
              dropped <= 1'b1;
            end
            if (last_edge) begin
              hit      <= 1'b0;
              i_idx    <= '0;
              last_idx <= count_next - CNT_W'(1);
              // Fewer than two edges: nothing to pair
              state    <= (count_next >= CNT_W'(2)) ? ST_FETCH : ST_FINISH;
            end
          end
        end

        ST_FETCH: begin
          rd_p  <= 1'b1;
          j_idx <= i_idx + ADDR_W'(1);
          state <= ST_SWEEP;
        end

        ST_SWEEP: begin
          rd_q <= 1'b1;
          if (CNT_W'(j_idx) == last_idx) begin
            // Row done: advance the fixed edge or drain once all rows ran
            if (CNT_W'(i_idx) + CNT_W'(1) == last_idx) begin
              state <= ST_DRAIN;
            end else begin
              i_idx <= i_idx + ADDR_W'(1);
              state <= ST_FETCH;
            end
          end else begin
            j_idx <= j_idx + ADDR_W'(1);
          end
        end

        ST_DRAIN: begin
          if (!rd_q && !pipe_busy) begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          // Hold until the output slot is free, then post and start a new set
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            overlap    <= hit;
            overflowed <= dropped;
            count      <= '0;
            dropped    <= 1'b0;
            state      <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  bso_pair_test u_pair_test (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (rd_q),
    .p          (p_seg),
    .q          (rdata),
    .tol        (tolerance),
    .res_valid  (res_valid),
    .res_hit    (res_hit),
    .busy       (pipe_busy)
  );

endmodule

/* sim/tb_boundary_segment_overlap_check.sv */
// ----------------------------------------------------------------------------
// tb_boundary_segment_overlap_check: self-checking bench for the overlap check
// Feeds sets of boundary edges through the input channel with bursty timing,
// predicts each set's overlap and overflow verdict in a local model of the
// pair test, and compares every result beat against the oldest prediction.
// Runs through several tolerance settings, including both extremes.
// ----------------------------------------------------------------------------
module tb_boundary_segment_overlap_check
  import bso_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Longest silent stretch allowed: must cover a sweep of a full edge store
  localparam int STALL_LIMIT      = 150000;
  localparam int RANDOM_PER_PHASE = 140;
  localparam int SETTLE_CYCLES    = 16;
  localparam int LONG_HOLD        = 4000;
  localparam int HOLD_AFTER_BEATS = 30;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   last;
  } edge_beat_t;

  typedef struct packed {
    logic overlap;
    logic overflowed;
  } verdict_t;

  typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;
  typedef enum int {SET_RING, SET_CLUSTER, SET_TOUCH, SET_WILD} set_kind_t;

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [TOL_W-1:0] cfg_data   = '0;
  logic             in_valid   = 1'b0;
  logic             in_ready;
  coord_t           start_x    = '0;
  coord_t           start_y    = '0;
  coord_t           end_x      = '0;
  coord_t           end_y      = '0;
  logic             last_edge  = 1'b0;
  logic             out_valid;
  logic             out_ready  = 1'b0;
  logic             overlap;
  logic             overflowed;

  // Edges waiting to be offered, and verdicts waiting for their result beat
  edge_beat_t pending_edges[$];
  verdict_t   expected_verdicts[$];

  // Local copy of the block's edge store, count, drop flag and tolerance register
  seg_t             edge_mem [MAX_EDGES];
  int               edge_cnt  = 0;
  bit               drop_seen = 1'b0;
  logic [TOL_W-1:0] tol_now   = TOL_RESET;

  int mismatches  = 0;
  int quiet_cycles = 0;

  boundary_segment_overlap_check dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .last_edge  (last_edge),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .overlap    (overlap),
    .overflowed (overflowed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Overlap predictor
  // --------------------------------------------------------------------------

  function automatic longint cross_z(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // Point c on the open segment a..b: near the line, strictly between the ends
  function automatic bit on_interior(longint ax, longint ay, longint cx, longint cy,
                                     longint bx, longint by);
    longint acx, acy, abx, aby, c, d, len2, tol;
    acx  = cx - ax;
    acy  = cy - ay;
    abx  = bx - ax;
    aby  = by - ay;
    tol  = longint'({32'b0, tol_now});
    c    = cross_z(acx, acy, abx, aby);
    d    = abx * acx + aby * acy;
    len2 = abx * abx + aby * aby;
    if (c < 0) c = -c;
    return (c <= tol) && (tol < d) && (d < len2);
  endfunction

  function automatic bit segs_overlap(seg_t p, seg_t q);
    longint pax, pay, pbx, pby, qax, qay, qbx, qby;
    int     s1, s2, s3, s4;
    pax = longint'($signed(p.ax));
    pay = longint'($signed(p.ay));
    pbx = longint'($signed(p.bx));
    pby = longint'($signed(p.by));
    qax = longint'($signed(q.ax));
    qay = longint'($signed(q.ay));
    qbx = longint'($signed(q.bx));
    qby = longint'($signed(q.by));
    // Proper crossing: strict opposite sides, both ways round
    s1 = sign_of(cross_z(pbx - pax, pby - pay, qax - pbx, qay - pby));
    s2 = sign_of(cross_z(pbx - pax, pby - pay, qbx - pbx, qby - pby));
    s3 = sign_of(cross_z(qbx - qax, qby - qay, pax - qbx, pay - qby));
    s4 = sign_of(cross_z(qbx - qax, qby - qay, pbx - qbx, pby - qby));
    if (s1 * s2 < 0 && s3 * s4 < 0) return 1'b1;
    // Touching: any endpoint on the other segment's open interior
    return on_interior(pax, pay, qax, qay, pbx, pby) ||
           on_interior(pax, pay, qbx, qby, pbx, pby) ||
           on_interior(qax, qay, pax, pay, qbx, qby) ||
           on_interior(qax, qay, pbx, pby, qbx, qby);
  endfunction

  // Advance the model by one accepted beat; a last edge closes the set
  function automatic void take_edge(edge_beat_t b);
    bit       hit;
    verdict_t v;
    hit = 1'b0;
    if (edge_cnt < MAX_EDGES) begin
      edge_mem[edge_cnt] = '{b.sx, b.sy, b.ex, b.ey};
      edge_cnt++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!b.last) return;
    for (int i = 0; i < edge_cnt && !hit; i++)
      for (int j = i + 1; j < edge_cnt && !hit; j++)
        if (segs_overlap(edge_mem[i], edge_mem[j])) hit = 1'b1;
    v.overlap    = hit;
    v.overflowed = drop_seen;
    expected_verdicts = {expected_verdicts, v};
    edge_cnt  = 0;
    drop_seen = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic void queue_edge(int sx, int sy, int ex, int ey, bit last);
    edge_beat_t b;
    b.sx   = coord_t'(sx);
    b.sy   = coord_t'(sy);
    b.ex   = coord_t'(ex);
    b.ey   = coord_t'(ey);
    b.last = last;
    pending_edges = {pending_edges, b};
  endfunction

  // Queue one random set and return how many edges it holds
  function automatic int queue_random_set();
    int        vx[12], vy[12];
    int        n, x0, y0, w, h, i, j, t, ax, ay, bx, by, cx, cy, dx, dy;
    set_kind_t kind;
    t = rnd(0, 99);
    kind = (t < 40) ? SET_RING : (t < 65) ? SET_CLUSTER : (t < 80) ? SET_TOUCH : SET_WILD;
    n = 0;
    case (kind)
      SET_RING: begin
        // Closed rectangle outline, some sides split; sometimes knotted
        x0 = rnd(-30000, 20000);
        y0 = rnd(-30000, 20000);
        w  = rnd(2, 10000);
        h  = rnd(2, 10000);
        for (int s = 0; s < 4; s++) begin
          vx[n] = (s == 1 || s == 2) ? x0 + w : x0;
          vy[n] = (s >= 2) ? y0 + h : y0;
          n++;
          if ($urandom_range(0, 1)) begin
            case (s)
              0:       begin vx[n] = x0 + rnd(1, w - 1); vy[n] = y0;                  end
              1:       begin vx[n] = x0 + w;             vy[n] = y0 + rnd(1, h - 1);  end
              2:       begin vx[n] = x0 + rnd(1, w - 1); vy[n] = y0 + h;              end
              default: begin vx[n] = x0;                 vy[n] = y0 + rnd(1, h - 1);  end
            endcase
            n++;
          end
        end
        if (rnd(0, 9) < 3) begin
          i = rnd(0, n - 1);
          j = (i + rnd(1, n - 1)) % n;
          t = vx[i]; vx[i] = vx[j]; vx[j] = t;
          t = vy[i]; vy[i] = vy[j]; vy[j] = t;
        end
        for (int k = 0; k < n; k++)
          queue_edge(vx[k], vy[k], vx[(k + 1) % n], vy[(k + 1) % n], k == n - 1);
      end
      SET_CLUSTER: begin
        // Short edges packed in a small area, so some of them meet
        x0 = rnd(-30000, 30000);
        y0 = rnd(-30000, 30000);
        n  = rnd(2, 8);
        for (int k = 0; k < n; k++) begin
          ax = x0 + rnd(-500, 500);
          ay = y0 + rnd(-500, 500);
          queue_edge(ax, ay, ax + rnd(-800, 800), ay + rnd(-800, 800), k == n - 1);
        end
      end
      SET_TOUCH: begin
        // Edge c..d starts near the midpoint of edge a..b, at its start point or beyond its end
        ax = rnd(-16000, 16000);
        ay = rnd(-16000, 16000);
        bx = ax + 2 * rnd(-4000, 4000);
        by = ay + 2 * rnd(-4000, 4000);
        case (rnd(0, 3))
          0, 1: begin cx = (ax + bx) / 2 + rnd(-2, 2); cy = (ay + by) / 2 + rnd(-2, 2); end
          2:    begin cx = ax;                         cy = ay;                         end
          default: begin cx = bx + (bx - ax) / 2;      cy = by + (by - ay) / 2;         end
        endcase
        dx = cx + rnd(-3000, 3000);
        dy = cy + rnd(-3000, 3000);
        n  = 2;
        if ($urandom_range(0, 1)) begin
          queue_edge(ax, ay, bx, by, 1'b0);
          queue_edge(cx, cy, dx, dy, 1'b1);
        end else begin
          queue_edge(dx, dy, cx, cy, 1'b0);
          queue_edge(bx, by, ax, ay, 1'b1);
        end
      end
      default: begin
        n = rnd(1, 6);
        for (int k = 0; k < n; k++)
          queue_edge(rnd(-32768, 32767), rnd(-32768, 32767),
                     rnd(-32768, 32767), rnd(-32768, 32767), k == n - 1);
      end
    endcase
    return n;
  endfunction

  // Hold until nothing is queued, offered or owed, then let the pipe settle
  task automatic wait_drained();
    while (pending_edges.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_now = value;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: bursts of beats separated by random gaps
  // --------------------------------------------------------------------------
  edge_beat_t beat_now;
  int         burst_left = 1;
  int         gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      // A beat offered last cycle was taken at this edge: fold it into the model
      if (in_valid) take_edge(beat_now);
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_edges.size() != 0) begin
        beat_now = pending_edges.pop_front();
        start_x   <= beat_now.sx;
        start_y   <= beat_now.sy;
        end_x     <= beat_now.ex;
        end_y     <= beat_now.ey;
        last_edge <= beat_now.last;
        in_valid  <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = rnd(1, 40);
          gap_left   = (rnd(0, 3) == 0) ? 0 : rnd(1, 15);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: stall pattern changes now and then at random; once,
  // after a few dozen beats, hold off long enough to back the block up
  // --------------------------------------------------------------------------
  rx_mode_t rx_mode   = RX_FREE;
  int       rx_left   = 0;
  int       rx_hold   = 0;
  int       rx_beats  = 0;
  bit       rx_held   = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_beats++;
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_beats == HOLD_AFTER_BEATS && !rx_held) begin
        rx_held = 1'b1;
        rx_hold = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'(rnd(0, 3));
          rx_left = rnd(32, 400);
        end else begin
          rx_left--;
        end
        case (rx_mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= (rnd(0, 3) == 0);
          default:   out_ready <= (rnd(0, 7) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each beat with the oldest predicted verdict
  // --------------------------------------------------------------------------
  verdict_t want_now;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result beat with none expected: overlap %0b overflowed %0b",
                 $time, overlap, overflowed);
        mismatches++;
      end else begin
        want_now = expected_verdicts.pop_front();
        if (overlap !== want_now.overlap) begin
          $display("%0t: overlap mismatch: expected %0b, got %0b",
                   $time, want_now.overlap, overlap);
          mismatches++;
        end
        if (overflowed !== want_now.overflowed) begin
          $display("%0t: overflowed mismatch: expected %0b, got %0b",
                   $time, want_now.overflowed, overflowed);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves a beat for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: directed sets at the reset tolerance, then random phases
  // --------------------------------------------------------------------------
  initial begin
    int queued;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Single edge spanning the whole range: no pair, so no overlap
    queue_edge(-32768, -32768, 32767, 32767, 1'b1);
    // Proper crossing
    queue_edge(-100, -100, 100, 100, 1'b0);
    queue_edge(-100, 100, 100, -100, 1'b1);
    // T-junction: endpoint on the other's interior
    queue_edge(0, 0, 200, 0, 1'b0);
    queue_edge(100, 0, 100, 50, 1'b1);
    // Shared endpoint only
    queue_edge(0, 0, 100, 0, 1'b0);
    queue_edge(100, 0, 100, 100, 1'b1);
    // Degenerate edge sitting on another edge, then one off the line
    queue_edge(50, 0, 50, 0, 1'b0);
    queue_edge(0, 0, 100, 0, 1'b1);
    queue_edge(7, 7, 7, 7, 1'b0);
    queue_edge(32767, -32768, -32768, 32767, 1'b1);
    // Collinear and disjoint, then collinear and overlapping
    queue_edge(0, 0, 10, 0, 1'b0);
    queue_edge(20, 0, 30, 0, 1'b1);
    queue_edge(0, 0, 20, 0, 1'b0);
    queue_edge(10, 0, 30, 0, 1'b1);
    // Parallel edges at the coordinate extremes
    queue_edge(-32768, 32767, 32767, 32767, 1'b0);
    queue_edge(-32768, -32768, 32767, -32768, 1'b1);

    // Store full: 256 parallel rungs, then a dropped last edge cutting them all
    for (int k = 0; k < MAX_EDGES; k++)
      queue_edge(-1000, -32000 + 250 * k, 1000, -32000 + 250 * k, 1'b0);
    queue_edge(0, -32768, 0, 32767, 1'b1);
    // Overfull set of wild edges; the next set must see the drop flag cleared
    for (int k = 0; k < MAX_EDGES + 4; k++)
      queue_edge(rnd(-32768, 32767), rnd(-32768, 32767),
                 rnd(-32768, 32767), rnd(-32768, 32767), k == MAX_EDGES + 3);

    for (int ph = 1; ph <= 5; ph++) begin
      wait_drained();
      case (ph)
        1:       write_tolerance('0);
        2:       write_tolerance('1);
        3:       write_tolerance($urandom);
        4:       write_tolerance($urandom_range(0, 1 << 22));
        default: write_tolerance(TOL_RESET);
      endcase
      queued = 0;
      while (queued < RANDOM_PER_PHASE) queued += queue_random_set();
    end

    wait_drained();
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (expected_verdicts.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_verdicts.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
